@@ src/windowed_median_filter_assert.svh @@
// Assertion macros used by the median filter queue.
`ifndef WINDOWED_MEDIAN_FILTER_ASSERT_SVH
`define WINDOWED_MEDIAN_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WMF_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("median filter: invariant violated");
`define WMF_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("median filter: sequence violated");
`else
`define WMF_ASSERT(lbl, expr)
`define WMF_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ src/wmf_pkg.sv @@
// Types and constants of the windowed median filter.
`timescale 1ns / 1ps
package wmf_pkg;
	localparam int WINDOW    = 3;
	localparam int HALF      = WINDOW / 2;
	localparam int NWIN      = WINDOW * WINDOW;
	localparam int MAX_WIDTH = 1024;
	localparam int PIX_W     = 8;
	localparam int CFG_W_W   = 11;
	localparam int CFG_H_W   = 12;
	localparam int COL_W     = $clog2(MAX_WIDTH + 1);
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int SLOT_W    = $clog2(WINDOW);
	localparam int RANK_W    = $clog2(NWIN);
	localparam int LEAD_W    = $clog2(HALF * MAX_WIDTH + HALF + 2);
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic REG_IDX_WIDTH  = 1'b0;
	localparam logic REG_IDX_HEIGHT = 1'b1;

	localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(640);
	localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(480);

	// One column shift for the back end, with the output decision attached.
	typedef struct packed {
		logic              wr;
		logic [PIX_W-1:0]  pixel;
		logic [ADDR_W-1:0] addr;
		logic [SLOT_W-1:0] slot;
		logic              emit;
		logic [WINDOW-1:0] rmask;
		logic [WINDOW-1:0] cmask;
		logic              last;
	} op_t;

	// Memory slot that holds the row at window position t of the current column.
	function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] slot, input int t);
		int s;
		s = int'(slot) + t + 1;
		if (s >= WINDOW) s = s - WINDOW;
		return SLOT_W'(s);
	endfunction
endpackage

@@ src/wmf_front.sv @@
// Front end: accepts items, tracks frame positions and issues column shifts.
`timescale 1ns / 1ps
module wmf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [wmf_pkg::CFG_W_W-1:0]  width,
	input  logic [wmf_pkg::CFG_H_W-1:0]  height,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [wmf_pkg::PIX_W-1:0]    pixel,
	input  logic                         drain,
	input  logic                         q_full,
	output logic                         push,
	output wmf_pkg::op_t                 op
);
	logic [wmf_pkg::COL_W-1:0]   ew, oc_q, ic_q, vc_q, oc, ic, vc;
	logic [wmf_pkg::CFG_H_W-1:0] eh, or_q, ir_q, orow, ir;
	logic [wmf_pkg::SLOT_W-1:0]  slot_q, slot;
	logic [wmf_pkg::LEAD_W-1:0]  lead_q, lead, thr;
	logic [wmf_pkg::LEAD_W-1:0]  pad_q, pad;
	logic                        shift, accept, step;
	logic [wmf_pkg::CFG_H_W:0]   rt;
	logic [wmf_pkg::COL_W:0]     ct;

	always_comb begin
		if (width == '0) ew = wmf_pkg::COL_W'(1);
		else if (int'(width) > wmf_pkg::MAX_WIDTH) ew = wmf_pkg::COL_W'(wmf_pkg::MAX_WIDTH);
		else ew = wmf_pkg::COL_W'(width);
		eh = (height == '0) ? wmf_pkg::CFG_H_W'(1) : height;
		thr = wmf_pkg::LEAD_W'(wmf_pkg::HALF) * wmf_pkg::LEAD_W'(ew)
			+ wmf_pkg::LEAD_W'(wmf_pkg::HALF);
	end

	assign item_ready = !q_full && pad_q == '0;
	assign accept     = item_valid && item_ready;
	assign step       = (pad_q != '0) ? !q_full : accept;

	always_comb begin
		oc = oc_q; orow = or_q; ic = ic_q; ir = ir_q;
		vc = vc_q; slot = slot_q; lead = lead_q; pad = pad_q;
		shift = 1'b0;
		op = '0;
		rt = '0;
		ct = '0;
		if (oc >= ew) begin
			oc = '0;
			orow = orow + 1'b1;
		end
		if (orow >= eh) begin
			oc = '0; orow = '0; ic = '0; ir = '0; vc = '0; slot = '0; lead = '0;
		end
		if (ir < eh && ic >= ew) begin
			ic = '0;
			ir = ir + 1'b1;
		end
		op.pixel = pixel;
		op.addr  = vc[wmf_pkg::ADDR_W-1:0];
		op.slot  = slot;
		if (pad_q != '0) begin
			// A frame too short to fill the window gets empty column shifts after its
			// last pixel, so the drain items see the window in the usual place.
			shift = 1'b1;
			pad = pad_q - 1'b1;
		end else if (!drain && ir < eh) begin
			op.wr = 1'b1;
			shift = 1'b1;
			ic = ic + 1'b1;
			if (ic >= ew) begin
				ic = '0;
				ir = ir + 1'b1;
			end
			lead = lead + 1'b1;
			op.emit = lead > thr;
			if (ir >= eh && lead < thr) pad = thr - lead;
		end else if (ir >= eh && orow < eh) begin
			shift = 1'b1;
			op.emit = 1'b1;
		end
		// Window validity of the output pixel, by row and by column offset.
		for (int t = 0; t < wmf_pkg::WINDOW; t++) begin
			rt = {1'b0, orow} + (wmf_pkg::CFG_H_W+1)'(t);
			op.rmask[t] = rt >= (wmf_pkg::CFG_H_W+1)'(wmf_pkg::HALF)
				&& rt < {1'b0, eh} + (wmf_pkg::CFG_H_W+1)'(wmf_pkg::HALF);
			ct = {1'b0, oc} + (wmf_pkg::COL_W+1)'(t);
			op.cmask[t] = ct >= (wmf_pkg::COL_W+1)'(wmf_pkg::HALF)
				&& ct < {1'b0, ew} + (wmf_pkg::COL_W+1)'(wmf_pkg::HALF);
		end
		op.last = (orow == eh - 1'b1) && (oc == ew - 1'b1);
		if (shift) begin
			vc = vc + 1'b1;
			if (vc >= ew) begin
				vc = '0;
				slot = (int'(slot) == wmf_pkg::WINDOW - 1) ? '0 : slot + 1'b1;
			end
		end
		if (op.emit) begin
			lead = lead - 1'b1;
			oc = oc + 1'b1;
			if (oc >= ew) begin
				oc = '0;
				orow = orow + 1'b1;
			end
			if (orow >= eh) begin
				oc = '0; orow = '0; ic = '0; ir = '0; vc = '0; slot = '0; lead = '0;
			end
		end
	end

	assign push = step && shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_q <= '0; or_q <= '0; ic_q <= '0; ir_q <= '0;
			vc_q <= '0; slot_q <= '0; lead_q <= '0; pad_q <= '0;
		end else if (step) begin
			oc_q <= oc; or_q <= orow; ic_q <= ic; ir_q <= ir;
			vc_q <= vc; slot_q <= slot; lead_q <= lead; pad_q <= pad;
		end
	end
endmodule

@@ src/wmf_queue.sv @@
// Short queue of column shifts between the front end and the back end.
`timescale 1ns / 1ps
`include "windowed_median_filter_assert.svh"
module wmf_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  wmf_pkg::op_t push_op,
	output logic         full,
	input  logic         pop,
	output logic         nonempty,
	output wmf_pkg::op_t head
);
	wmf_pkg::op_t                mem_q [wmf_pkg::QDEPTH];
	logic [wmf_pkg::QPTR_W-1:0]  wp_q, rp_q;
	logic [wmf_pkg::QCNT_W-1:0]  count_q;

	assign full     = count_q == wmf_pkg::QCNT_W'(wmf_pkg::QDEPTH);
	assign nonempty = count_q != '0;
	assign head     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	`WMF_ASSERT(a_q_count_range, count_q <= wmf_pkg::QCNT_W'(wmf_pkg::QDEPTH))
	`WMF_ASSERT(a_q_no_overflow, !(push && full))
	`WMF_ASSERT(a_q_no_underflow, !(pop && !nonempty))
	`WMF_ASSERT_NEXT(a_q_last_pop, count_q == 1 && pop && !push, !nonempty)
endmodule

@@ src/wmf_back.sv @@
// Back end: line stores, window shift, rank sort and result register.
`timescale 1ns / 1ps
module wmf_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       op_valid,
	input  wmf_pkg::op_t               op,
	output logic                       pop,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic [wmf_pkg::PIX_W-1:0]  median_value,
	output logic                       last_of_frame
);
	localparam int W = wmf_pkg::WINDOW;
	localparam int N = wmf_pkg::NWIN;

	logic                       adv;
	logic [wmf_pkg::PIX_W-1:0]  rd_s1 [W];
	wmf_pkg::op_t               op_s1;
	logic                       v_s1, v_s2, v_s3, out_valid_q;
	logic [wmf_pkg::PIX_W-1:0]  col [W];
	logic [wmf_pkg::PIX_W-1:0]  win_q [W][W];
	logic [W-1:0]               rmask_s2, cmask_s2;
	logic                       last_s2, last_s3, last_q;
	logic [wmf_pkg::PIX_W-1:0]  vals [N];
	logic [N-1:0]               vld;
	logic [N-1:0]               lt [N];
	logic [wmf_pkg::PIX_W-1:0]  vals_s3 [N];
	logic [N-1:0]               vld_s3;
	logic [wmf_pkg::RANK_W-1:0] rank_s3 [N];
	logic [wmf_pkg::RANK_W-1:0] mid_s3;
	logic [N-1:0]               match;
	logic [wmf_pkg::PIX_W-1:0]  med, median_q;

	// The whole pipeline moves together; it holds only while a result waits.
	assign adv = !out_valid_q || result_ready;
	assign pop = adv && op_valid;

	for (genvar m = 0; m < W; m++) begin : g_line
		logic [wmf_pkg::PIX_W-1:0] mem [wmf_pkg::MAX_WIDTH];
		always_ff @(posedge clk) begin
			if (pop) begin
				if (op.wr && op.slot == wmf_pkg::SLOT_W'(m)) mem[op.addr] <= op.pixel;
				rd_s1[m] <= mem[op.addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) op_s1 <= op;
	end

	// Oldest row on top; the newest row is the pixel of this item itself.
	always_comb begin
		for (int t = 0; t < W - 1; t++) col[t] = rd_s1[wmf_pkg::slot_of(op_s1.slot, t)];
		col[W-1] = op_s1.pixel;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			for (int j = 0; j < W - 1; j++) win_q[j] <= win_q[j+1];
			win_q[W-1] <= col;
			rmask_s2 <= op_s1.rmask;
			cmask_s2 <= op_s1.cmask;
			last_s2  <= op_s1.last;
		end
	end

	// Rank of each value among the valid ones, ties broken by position.
	always_comb begin
		for (int j = 0; j < W; j++) begin
			for (int t = 0; t < W; t++) begin
				vals[j*W+t] = win_q[j][t];
				vld[j*W+t]  = rmask_s2[t] && cmask_s2[j];
			end
		end
		for (int i = 0; i < N; i++) begin
			for (int k = 0; k < N; k++) begin
				lt[i][k] = vld[k] && (vals[k] < vals[i] || (vals[k] == vals[i] && k < i));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < N; i++) begin
				vals_s3[i] <= vals[i];
				rank_s3[i] <= wmf_pkg::RANK_W'($countones(lt[i]));
			end
			vld_s3  <= vld;
			mid_s3  <= wmf_pkg::RANK_W'($countones(vld) / 2);
			last_s3 <= last_s2;
		end
	end

	always_comb begin
		med = '0;
		for (int i = 0; i < N; i++) begin
			match[i] = vld_s3[i] && rank_s3[i] == mid_s3;
			if (match[i]) med = med | vals_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			median_q <= med;
			last_q   <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1 && op_s1.emit;
			v_s3 <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	assign result_valid  = out_valid_q;
	assign median_value  = median_q;
	assign last_of_frame = last_q;
endmodule

@@ src/windowed_median_filter.sv @@
// Top level of the windowed median filter with its register port.
`timescale 1ns / 1ps
// Streaming 3x3 median filter for 8-bit grey pixels in raster order. It takes
// one item per clock while the queue has room; each item becomes a column
// shift through a four-entry queue, a line-store read, a window shift, a rank
// stage and the result register that offers it. The result for a pixel is
// released by the pixel one row and one column later; after the last pixel of
// a frame, send drain items, one per result still pending. A frame only one
// row high needs one extra internal column shift after its last pixel, so
// item_ready drops while that shift is issued.
// Window places outside the image are left out, and the result is the upper
// median of what remains. Line stores are one memory of MAX_WIDTH pixels per
// window row, one write and one read each per cycle.
// Registers: image_width at address 0, image_height at address 4.
module windowed_median_filter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [wmf_pkg::PIX_W-1:0]    pixel,
	input  logic                         drain,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [wmf_pkg::PIX_W-1:0]    median_value,
	output logic                         last_of_frame
);
	logic [wmf_pkg::CFG_W_W-1:0] width_q;
	logic [wmf_pkg::CFG_H_W-1:0] height_q;
	logic                        push, q_full, q_nonempty, pop;
	wmf_pkg::op_t                push_op, head;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= wmf_pkg::WIDTH_RESET;
			height_q <= wmf_pkg::HEIGHT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				wmf_pkg::REG_IDX_WIDTH:  width_q  <= pwdata[wmf_pkg::CFG_W_W-1:0];
				wmf_pkg::REG_IDX_HEIGHT: height_q <= pwdata[wmf_pkg::CFG_H_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			wmf_pkg::REG_IDX_WIDTH:  prdata = 32'(width_q);
			wmf_pkg::REG_IDX_HEIGHT: prdata = 32'(height_q);
			default:                 prdata = '0;
		endcase
	end

	wmf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.width      (width_q),
		.height     (height_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.pixel      (pixel),
		.drain      (drain),
		.q_full     (q_full),
		.push       (push),
		.op         (push_op)
	);

	wmf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_op  (push_op),
		.full     (q_full),
		.pop      (pop),
		.nonempty (q_nonempty),
		.head     (head)
	);

	wmf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.op_valid      (q_nonempty),
		.op            (head),
		.pop           (pop),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.median_value  (median_value),
		.last_of_frame (last_of_frame)
	);
endmodule
